// ===== sv/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue with duplicate-key rejection.
// Used by spq_ctrl and sorted_priority_queue_dedup; no dependencies.
package spq_pkg;

  // Queue size; IDX_W and CNT_W follow from it, while FILL_W is fixed
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int FILL_W      = 5;

  // Action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // Input beat
  typedef struct packed {
    logic        action;
    logic [31:0] job_key;
    logic [15:0] job_priority;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [1:0]        status;
    logic [31:0]       out_key;
    logic [15:0]       out_priority;
    logic [FILL_W-1:0] fill_level;
  } out_item_t;

  // One stored slot
  typedef struct packed {
    logic [31:0] key;
    logic [15:0] prio;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Slot store access from the sequencer
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_t            wr_data;
    logic [IDX_W-1:0] rd_addr;
  } ram_req_t;

endpackage

// ===== sv/spq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/spq_ctrl.sv =====
// Sequencer of the sorted priority queue: scan for duplicates and insert
// position, shift slots up, place or pop. Depends on spq_pkg and drives the slot RAM.
module spq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  spq_pkg::in_item_t   in_data,
  output logic                in_stall,
  output spq_pkg::ram_req_t   ram_req,
  input  spq_pkg::slot_t      ram_rd_data,
  output logic                res_valid,
  output spq_pkg::out_item_t  res_data,
  input  logic                res_take
);
  import spq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_SHIFT = 6'b000100,
    S_PLACE = 6'b001000,
    S_POPRD = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  in_item_t         item_r, item_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [CNT_W-1:0] chk_idx_r, chk_idx_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] sh_idx_r, sh_idx_nxt;
  logic             sh_issue_r, sh_issue_nxt;
  logic             sh_vld_r, sh_vld_nxt;
  logic [IDX_W-1:0] sh_src_r, sh_src_nxt;
  logic [1:0]       st_r, st_nxt;
  slot_t            pop_r, pop_nxt;

  logic [CNT_W-1:0] cnt_m1;
  logic             accept;
  logic             hit_key;
  logic             hit_pos;
  logic [CNT_W-1:0] fpos;

  assign cnt_m1  = count_r - CNT_W'(1);
  assign accept  = in_valid && (state_r == S_IDLE);
  assign hit_key = (ram_rd_data.key == item_r.job_key);
  assign hit_pos = (item_r.job_priority >= ram_rd_data.prio);
  assign fpos    = found_r ? pos_r : (hit_pos ? chk_idx_r : count_r);

  // Next-state and datapath sequencing
  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    count_nxt    = count_r;
    scan_nxt     = scan_r;
    chk_vld_nxt  = 1'b0;
    chk_idx_nxt  = scan_r;
    pos_nxt      = pos_r;
    found_nxt    = found_r;
    sh_idx_nxt   = sh_idx_r;
    sh_issue_nxt = sh_issue_r;
    sh_vld_nxt   = 1'b0;
    sh_src_nxt   = sh_idx_r;
    st_nxt       = st_r;
    pop_nxt      = pop_r;

    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = pos_r[IDX_W-1:0];
    ram_req.wr_data = '{key: item_r.job_key, prio: item_r.job_priority};
    ram_req.rd_addr = cnt_m1[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt = in_data;
          if (in_data.action == ACT_POP) begin
            if (count_r == '0) begin
              st_nxt    = ST_EMPTY;
              pop_nxt   = '0;
              state_nxt = S_RESP;
            end else begin
              // read of the top slot is issued now
              state_nxt = S_POPRD;
            end
          end else if (count_r >= CNT_W'(QUEUE_DEPTH)) begin
            st_nxt    = ST_FULL;
            pop_nxt   = '0;
            state_nxt = S_RESP;
          end else if (count_r == '0) begin
            pos_nxt   = '0;
            state_nxt = S_PLACE;
          end else begin
            scan_nxt  = '0;
            found_nxt = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // issue one slot read per cycle, check it the cycle after
        ram_req.rd_addr = scan_r[IDX_W-1:0];
        if (scan_r < count_r) begin
          chk_vld_nxt = 1'b1;
          scan_nxt    = scan_r + CNT_W'(1);
        end
        if (chk_vld_r) begin
          if (!found_r && hit_pos) begin
            found_nxt = 1'b1;
            pos_nxt   = chk_idx_r;
          end
          if (hit_key) begin
            st_nxt      = ST_DUP;
            pop_nxt     = '0;
            chk_vld_nxt = 1'b0;
            state_nxt   = S_RESP;
          end else if (chk_idx_r == cnt_m1) begin
            chk_vld_nxt = 1'b0;
            pos_nxt     = fpos;
            if (fpos == count_r) begin
              state_nxt = S_PLACE;
            end else begin
              sh_idx_nxt   = cnt_m1[IDX_W-1:0];
              sh_issue_nxt = 1'b1;
              state_nxt    = S_SHIFT;
            end
          end
        end
      end

      S_SHIFT: begin
        // read slot i, write it to slot i+1 in the next cycle, from the top down
        ram_req.rd_addr = sh_idx_r;
        if (sh_issue_r) begin
          sh_vld_nxt = 1'b1;
          sh_src_nxt = sh_idx_r;
          if (sh_idx_r == pos_r[IDX_W-1:0]) begin
            sh_issue_nxt = 1'b0;
          end else begin
            sh_idx_nxt = sh_idx_r - IDX_W'(1);
          end
        end
        if (sh_vld_r) begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = sh_src_r + IDX_W'(1);
          ram_req.wr_data = ram_rd_data;
          if (!sh_issue_r) begin
            state_nxt = S_PLACE;
          end
        end
      end

      S_PLACE: begin
        ram_req.wr_en = 1'b1;
        count_nxt     = count_r + CNT_W'(1);
        st_nxt        = ST_OK;
        pop_nxt       = '0;
        state_nxt     = S_RESP;
      end

      S_POPRD: begin
        count_nxt = cnt_m1;
        st_nxt    = ST_OK;
        pop_nxt   = ram_rd_data;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      chk_vld_r  <= 1'b0;
      found_r    <= 1'b0;
      sh_issue_r <= 1'b0;
      sh_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      chk_vld_r  <= chk_vld_nxt;
      found_r    <= found_nxt;
      sh_issue_r <= sh_issue_nxt;
      sh_vld_r   <= sh_vld_nxt;
    end
  end

  // Payload and index registers
  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    scan_r    <= scan_nxt;
    chk_idx_r <= chk_idx_nxt;
    pos_r     <= pos_nxt;
    sh_idx_r  <= sh_idx_nxt;
    sh_src_r  <= sh_src_nxt;
    st_r      <= st_nxt;
    pop_r     <= pop_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_RESP);

  always_comb begin
    res_data.status       = st_r;
    res_data.out_key      = pop_r.key;
    res_data.out_priority = pop_r.prio;
    res_data.fill_level   = FILL_W'(count_r);
  end

endmodule

// ===== sv/sorted_priority_queue_dedup.sv =====
// Sorted priority queue with duplicate-key rejection: one beat per operation.
// One operation at a time: the next beat is taken only when the sequencer is back in idle,
// after the scan of the held entries (cut short on a duplicate) and the shift of those from
// the insert position up, both through the single slot RAM port.
// Reset clears the entry count and the sequencer; slot contents stay undefined and unread.
module sorted_priority_queue_dedup (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  spq_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output spq_pkg::out_item_t  out_data
);
  import spq_pkg::*;

  ram_req_t  ram_req;
  slot_t     ram_rd_data;
  logic      res_valid;
  out_item_t res_data;
  logic      res_take;
  logic      out_valid_r;
  out_item_t out_data_r;

  spq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .in_stall    (in_stall),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data),
    .res_valid   (res_valid),
    .res_data    (res_data),
    .res_take    (res_take)
  );

  spq_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rd_data)
  );

  // Output register: load when empty or being drained
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sim/spq_checker.sv =====
// Checker for sorted_priority_queue_dedup: watches both channels and keeps a shadow queue.
// Predicts the reply beat of every accepted operation and compares replies in order.
// Depends on spq_pkg for the beat types, depth and status codes.
module spq_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  spq_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  spq_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 replies_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  // Shadow copy of the queue; slot 0 least urgent, top slot most urgent
  logic [31:0] shadow_key  [QUEUE_DEPTH];
  logic [15:0] shadow_prio [QUEUE_DEPTH];
  int          shadow_count;

  // Predicted replies, oldest first
  out_item_t   op_replies[$];
  int          mismatches;

  // Apply one operation to the shadow queue and form its reply beat
  task automatic apply_queue_op(input in_item_t beat, output out_item_t reply);
    int pos;
    bit dup;
    reply = '0;
    dup   = 1'b0;
    if (beat.action == ACT_INSERT) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        // full wins over duplicate
        reply.status = ST_FULL;
      end else begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_key[i] == beat.job_key) dup = 1'b1;
        end
        if (dup) begin
          reply.status = ST_DUP;
        end else begin
          // first slot whose priority number is not above ours; ties land below older ones, popped first
          pos = shadow_count;
          for (int i = 0; i < shadow_count; i++) begin
            if (pos == shadow_count && beat.job_priority >= shadow_prio[i]) pos = i;
          end
          for (int i = shadow_count; i > pos; i--) begin
            shadow_key[i]  = shadow_key[i-1];
            shadow_prio[i] = shadow_prio[i-1];
          end
          shadow_key[pos]  = beat.job_key;
          shadow_prio[pos] = beat.job_priority;
          shadow_count++;
          reply.status = ST_OK;
        end
      end
    end else if (shadow_count == 0) begin
      reply.status = ST_EMPTY;
    end else begin
      shadow_count--;
      reply.status       = ST_OK;
      reply.out_key      = shadow_key[shadow_count];
      reply.out_priority = shadow_prio[shadow_count];
    end
    reply.fill_level = shadow_count[FILL_W-1:0];
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Track both channels at each rising edge
  always @(posedge clk) begin
    out_item_t predicted;
    out_item_t oldest;
    if (!rst_n) begin
      shadow_count = 0;
      op_replies.delete();
    end else begin
      if (in_valid && !in_stall) begin
        apply_queue_op(in_data, predicted);
        op_replies.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (op_replies.size() == 0) begin
          $display("%0t ns: unexpected reply beat, expected none, actual 0x%0h",
                   $time, out_data);
          mismatches++;
        end else begin
          oldest = op_replies.pop_front();
          check_field("status", 32'(oldest.status), 32'(out_data.status));
          check_field("out_key", oldest.out_key, out_data.out_key);
          check_field("out_priority", 32'(oldest.out_priority), 32'(out_data.out_priority));
          check_field("fill_level", 32'(oldest.fill_level), 32'(out_data.fill_level));
        end
      end
    end
    replies_owed <= op_replies.size();
    fail_count   <= mismatches;
  end

endmodule

// ===== sim/tb_top.sv =====
// Top of the sorted_priority_queue_dedup testbench: clock, reset, operation stimulus, verdict.
// Instantiates the block and spq_checker; depends on spq_pkg for beat types and codes.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int PHASE_OPS       = 312;
  localparam int TAIL_CYCLES     = 60;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int fail_count;
  int replies_owed;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;

  sorted_priority_queue_dedup u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  spq_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .replies_owed (replies_owed)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one beat; called and returns at a falling edge
  task automatic send_beat(input logic act, input logic [31:0] key, input logic [15:0] prio);
    int gap;
    gap = 0;
    if (idle_pct > 0) begin
      if ($urandom_range(7) == 0) gap = $urandom_range(60, 1);
      else while ($urandom_range(99) < idle_pct) gap++;
    end
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid             <= 1'b1;
    in_data.action       <= act;
    in_data.job_key      <= key;
    in_data.job_priority <= prio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Keys: mostly a small pool so duplicates are common
  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) return 32'($urandom_range(23));
    if (sel < 60) return 32'h0;
    if (sel < 65) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Priorities: a narrow band for ties, extremes, full range
  function automatic logic [15:0] pick_prio();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return 16'($urandom_range(3));
    if (sel < 45) return 16'h0;
    if (sel < 50) return 16'hFFFF;
    return 16'($urandom_range(65535));
  endfunction

  // Random operations in bursts that lean to filling, draining or neither
  task automatic run_random_ops(input int count);
    int sent;
    int burst;
    int ins_pct;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(40, 8);
      case ($urandom_range(2))
        0: ins_pct = 85;
        1: ins_pct = 50;
        default: ins_pct = 15;
      endcase
      repeat (burst) begin
        send_beat(($urandom_range(99) < ins_pct) ? ACT_INSERT : ACT_POP,
                  pick_key(), pick_prio());
      end
      sent += burst;
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty pop, extreme keys and priorities, duplicate, ties served oldest first
    send_beat(ACT_POP,    32'h0,         16'h0);
    send_beat(ACT_INSERT, 32'h0,         16'hFFFF);
    send_beat(ACT_INSERT, 32'hFFFF_FFFF, 16'h0);
    send_beat(ACT_INSERT, 32'h0,         16'h1);
    send_beat(ACT_INSERT, 32'h5,         16'hFFFF);
    send_beat(ACT_INSERT, 32'h6,         16'h0);
    send_beat(ACT_INSERT, 32'h7,         16'h8000);
    repeat (6) send_beat(ACT_POP, $urandom, 16'($urandom_range(65535)));
    // Fill to the top, then a new key and a held key against a full queue
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      send_beat(ACT_INSERT, 32'(100 + i), 16'(i % 3));
    end
    send_beat(ACT_INSERT, 32'h1234_5678, 16'h0);
    send_beat(ACT_INSERT, 32'd100,       16'h0);
    in_valid <= 1'b0;

    // Random phases: no idling, sender idle, receiver stalling, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      @(negedge clk);
      run_random_ops(PHASE_OPS);
      in_valid <= 1'b0;
      @(posedge clk);
      while (replies_owed != 0) @(posedge clk);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/spq_pkg.sv
sv/spq_ram.sv
sv/spq_ctrl.sv
sv/sorted_priority_queue_dedup.sv
sim/spq_checker.sv
sim/tb_top.sv
